// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL. Build with NO_ASSERTIONS to drop them.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define SID_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SID_ASSERT_IMPL(label, ante, cons, msg)
`define SID_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- rtl/sid_pkg.sv -----
`default_nettype none

package sid_pkg;

    // Default operand width.
    localparam int DATA_WIDTH_DEF = 32;

    // Per-request flags carried down the divider array.
    typedef struct packed {
        logic neg_a;    // dividend was negative
        logic neg_q;    // quotient must be negated
        logic dbz;      // divisor was zero
        logic ovf;      // most negative / -1
    } side_t;

endpackage

`default_nettype wire

// ----- rtl/signed_integer_divider.sv -----
// Signed integer divider, quotient truncated toward zero.
//
// Input channel: in_valid/in_ready carry one dividend/divisor request.
// Output channel: out_valid/out_ready carry quotient, divide_by_zero and
// overflow for that request, in request order.
//
// The pipeline has one operand stage that takes magnitudes and flags, one
// array cell per quotient bit, and one result stage that restores the
// sign. Throughput is one request per cycle while out_ready is high; every
// stage is a register with its own valid bit, so empty slots collapse and
// a new request is taken while a result waits in the output register.
//
// Divide by zero returns +max (or -max for a negative dividend) with
// divide_by_zero set; most negative / -1 returns +max with overflow set.
//
// Reset clears all valid bits; the array comes up empty and ready.
// When the receiver stalls, the results back up stage by stage; in_ready
// drops only once every stage holds a request.
`default_nettype none

module signed_integer_divider #(
    parameter int DATA_WIDTH = sid_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [DATA_WIDTH-1:0] dividend,
    input  wire logic signed [DATA_WIDTH-1:0] divisor,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0]      quotient,
    output logic                              divide_by_zero,
    output logic                              overflow
);
    import sid_pkg::*;

    localparam logic [DATA_WIDTH-1:0] MIN_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] NEG_MAX = {1'b1, {(DATA_WIDTH-2){1'b0}}, 1'b1};
    localparam logic [DATA_WIDTH-1:0] ALL_ONE = {DATA_WIDTH{1'b1}};
    localparam logic [DATA_WIDTH-1:0] ONE     = {{(DATA_WIDTH-1){1'b0}}, 1'b1};

    // ---------------- operand stage ----------------
    logic                  op_valid_reg;
    logic                  op_valid_next;
    logic [DATA_WIDTH-1:0] a_mag_reg;
    logic [DATA_WIDTH-1:0] a_mag_next;
    logic [DATA_WIDTH-1:0] b_mag_reg;
    logic [DATA_WIDTH-1:0] b_mag_next;
    side_t                 op_side_reg;
    side_t                 op_side_next;
    logic                  op_dst_ready;

    always_comb
    begin
        op_side_next.neg_a = dividend[DATA_WIDTH-1];
        op_side_next.neg_q = dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
        op_side_next.dbz   = (divisor == '0);
        op_side_next.ovf   = (dividend == MIN_NEG) && (divisor == ALL_ONE);
        // most negative maps to 2^(W-1), which still fits unsigned
        a_mag_next = dividend[DATA_WIDTH-1] ? (~dividend + ONE) : dividend;
        b_mag_next = divisor[DATA_WIDTH-1]  ? (~divisor + ONE)  : divisor;
    end

    assign in_ready      = !op_valid_reg || op_dst_ready;
    assign op_valid_next = in_ready ? in_valid : op_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
        end
        else
        begin
            op_valid_reg <= op_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            a_mag_reg   <= a_mag_next;
            b_mag_reg   <= b_mag_next;
            op_side_reg <= op_side_next;
        end
    end

    // ---------------- divider array ----------------
    logic                  chain_valid [0:DATA_WIDTH];
    logic                  chain_ready [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] chain_rem   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] chain_num   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] chain_den   [0:DATA_WIDTH];
    side_t                 chain_side  [0:DATA_WIDTH];

    assign chain_valid[0] = op_valid_reg;
    assign op_dst_ready   = chain_ready[0];
    assign chain_rem[0]   = '0;
    assign chain_num[0]   = a_mag_reg;
    assign chain_den[0]   = b_mag_reg;
    assign chain_side[0]  = op_side_reg;

    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_cell
        sid_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .src_valid (chain_valid[i]),
            .src_ready (chain_ready[i]),
            .src_rem   (chain_rem[i]),
            .src_num   (chain_num[i]),
            .src_den   (chain_den[i]),
            .src_side  (chain_side[i]),
            .dst_valid (chain_valid[i+1]),
            .dst_ready (chain_ready[i+1]),
            .dst_rem   (chain_rem[i+1]),
            .dst_num   (chain_num[i+1]),
            .dst_den   (chain_den[i+1]),
            .dst_side  (chain_side[i+1])
        );
    end

    // ---------------- result stage ----------------
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [DATA_WIDTH-1:0] quotient_reg;
    logic [DATA_WIDTH-1:0] quotient_next;
    logic                  dbz_reg;
    logic                  ovf_reg;
    logic                  res_ready;
    logic [DATA_WIDTH-1:0] q_mag;
    side_t                 res_side;

    assign q_mag    = chain_num[DATA_WIDTH];
    assign res_side = chain_side[DATA_WIDTH];

    always_comb
    begin
        if (res_side.dbz)
        begin
            quotient_next = res_side.neg_a ? NEG_MAX : MAX_POS;
        end
        else if (res_side.ovf)
        begin
            quotient_next = MAX_POS;
        end
        else
        begin
            quotient_next = res_side.neg_q ? (~q_mag + ONE) : q_mag;
        end
    end

    assign res_ready               = !out_valid_reg || out_ready;
    assign chain_ready[DATA_WIDTH] = res_ready;
    assign out_valid_next          = res_ready ? chain_valid[DATA_WIDTH] : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && chain_valid[DATA_WIDTH])
        begin
            quotient_reg <= quotient_next;
            dbz_reg      <= res_side.dbz;
            ovf_reg      <= res_side.ovf && !res_side.dbz;
        end
    end

    assign out_valid      = out_valid_reg;
    assign quotient       = quotient_reg;
    assign divide_by_zero = dbz_reg;
    assign overflow       = ovf_reg;

    // ---------------- assertions ----------------
    logic dbz_q_ok;
    logic ovf_req;

    assign dbz_q_ok = (quotient_reg == MAX_POS) || (quotient_reg == NEG_MAX);
    assign ovf_req  = in_valid && in_ready && (dividend == MIN_NEG) && (divisor == ALL_ONE);

`include "assert_macros.svh"

    `SID_ASSERT_IMPL(a_flags_excl, out_valid, !(divide_by_zero && overflow), "both flags set")
    `SID_ASSERT_IMPL(a_ovf_sat, out_valid && overflow, quotient_reg == MAX_POS, "ovf sat")
    `SID_ASSERT_IMPL(a_dbz_value, out_valid && divide_by_zero, dbz_q_ok, "bad dbz quotient")
    `SID_ASSERT_IMPL(a_empty_ready, !out_valid_reg, in_ready, "in_ready low, empty")
    `SID_ASSERT_NEXT(a_ovf_input, ovf_req, op_side_reg.ovf, "ovf flag not captured")

endmodule

`default_nettype wire

// ----- rtl/sid_cell.sv -----
`default_nettype none

module sid_cell #(
    parameter int DATA_WIDTH = sid_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   src_valid,
    output logic                        src_ready,
    input  wire logic [DATA_WIDTH-1:0]  src_rem,
    input  wire logic [DATA_WIDTH-1:0]  src_num,
    input  wire logic [DATA_WIDTH-1:0]  src_den,
    input  wire sid_pkg::side_t         src_side,
    output logic                        dst_valid,
    input  wire logic                   dst_ready,
    output logic [DATA_WIDTH-1:0]       dst_rem,
    output logic [DATA_WIDTH-1:0]       dst_num,
    output logic [DATA_WIDTH-1:0]       dst_den,
    output sid_pkg::side_t              dst_side
);
    import sid_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH-1:0] num_reg;
    logic [DATA_WIDTH-1:0] num_next;
    logic [DATA_WIDTH-1:0] den_reg;
    side_t                 side_reg;
    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  qbit;

    // One restoring step: shift in the next dividend bit, trial subtract.
    always_comb
    begin
        shifted  = {src_rem, src_num[DATA_WIDTH-1]};
        diff     = shifted - {1'b0, src_den};
        qbit     = !diff[DATA_WIDTH];
        rem_next = qbit ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
        // quotient bits fill the low end as dividend bits leave the top
        num_next = {src_num[DATA_WIDTH-2:0], qbit};
    end

    assign src_ready  = !valid_reg || dst_ready;
    assign valid_next = src_ready ? src_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_ready && src_valid)
        begin
            rem_reg  <= rem_next;
            num_reg  <= num_next;
            den_reg  <= src_den;
            side_reg <= src_side;
        end
    end

    assign dst_valid = valid_reg;
    assign dst_rem   = rem_reg;
    assign dst_num   = num_reg;
    assign dst_den   = den_reg;
    assign dst_side  = side_reg;

endmodule

`default_nettype wire
